FILE: hdl/mfsd_pkg.sv
// Shared types, constants and the power-of-ten table for the MDER float decoder.
package mfsd_pkg;

  typedef enum logic [2:0] {
    CLS_FINITE   = 3'd0,
    CLS_POS_INF  = 3'd1,
    CLS_NAN      = 3'd2,
    CLS_NRES     = 3'd3,
    CLS_RESERVED = 3'd4,
    CLS_NEG_INF  = 3'd5
  } cls_t;

  localparam logic [23:0] FLOAT_RES_FIRST  = 24'h7FFFFE;
  localparam logic [23:0] FLOAT_RES_LAST   = 24'h800002;
  localparam logic [11:0] SFLOAT_RES_FIRST = 12'h7FE;
  localparam logic [11:0] SFLOAT_RES_LAST  = 12'h802;
  localparam logic [7:0]  SFLOAT_IDX_BASE  = 8'd120;

  localparam logic [63:0] BITS_POS_INF = 64'h7FF0000000000000;
  localparam logic [63:0] BITS_QNAN    = 64'h7FF8000000000000;
  localparam logic [63:0] BITS_NEG_INF = 64'hFFF0000000000000;

  // Nearest double to 10^e, worked out exactly with wide integers at elaboration.
  function automatic logic [63:0] pow10_bits(int e);
    logic [511:0] d;
    logic [511:0] q;
    logic [511:0] rem;
    logic [511:0] low;
    logic [52:0]  sig;
    logic         g;
    logic         st;
    logic [63:0]  r;
    int           k;
    int           n;
    int           p;
    k = (e < 0) ? -e : e;
    d = 512'd1;
    for (int i = 0; i < 128; i++) begin
      if (i < k) begin
        d = (d << 3) + (d << 1);
      end
    end
    q   = '0;
    rem = '0;
    if (e >= 0) begin
      q = d << 64;
      n = 64;
    end else begin
      n = 500;
      for (int b = 500; b >= 0; b--) begin
        rem = {rem[510:0], (b == 500)};
        if (rem >= d) begin
          rem  = rem - d;
          q[b] = 1'b1;
        end
      end
    end
    p = 0;
    for (int b = 0; b < 512; b++) begin
      if (q[b]) begin
        p = b;
      end
    end
    sig = 53'(q >> (p - 52));
    g   = q[p - 53];
    low = q << (512 - (p - 53));
    st  = (low != '0) || (rem != '0);
    r   = {1'b0, 11'(p - n + 1023), sig[51:0]};
    if (g && (st || sig[0])) begin
      r = r + 64'd1;
    end
    return r;
  endfunction

  function automatic logic [255:0][63:0] build_rom();
    logic [255:0][63:0] t;
    for (int i = 0; i < 256; i++) begin
      t[i] = pow10_bits(i - 128);
    end
    return t;
  endfunction

  localparam logic [255:0][63:0] POW10_ROM = build_rom();

endpackage

FILE: hdl/mder_float_sfloat_decode_core.sv
// Top level of the MDER FLOAT/SFLOAT decoder: pipelined decode to IEEE-754 double bits.
//
// The input channel (in_valid, in_ready) takes one item per cycle while in_ready
// is high: in_op selects 32-bit FLOAT (0) or 16-bit SFLOAT (1), and in_raw_word
// holds the received word. The result channel (out_valid, out_ready) gives one
// item per input item, in order: out_value_bits is the double bit pattern and
// out_value_class the class. The pipeline is an input register, a decode stage
// with the power-of-ten table, a stage of two partial products, a product sum
// stage, a double rounding stage and the result register. One item per cycle is
// sustained while the receiver takes results; the split multiplier sets the
// pipeline depth. When the receiver stalls, the whole pipeline holds and in_ready
// falls; items in flight are kept. Reset empties the pipeline and drops out_valid.
// There is no configuration and no state beyond the items in flight.
module mder_float_sfloat_decode_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_raw_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value_bits,
  output logic [2:0]  out_value_class
);

  logic en;

  logic        v0_r;
  logic        op0_r;
  logic [31:0] word0_r;

  logic              v1_r, op1_r, rsv1_r, zero1_r, sign1_r;
  mfsd_pkg::cls_t    cls1_r;
  logic [23:0]       magn1_r;
  logic [10:0]       exp1_r;
  logic [52:0]       sig1_r;

  logic              v2_r, op2_r, rsv2_r, zero2_r, sign2_r;
  mfsd_pkg::cls_t    cls2_r;
  logic [10:0]       exp2_r;
  logic [50:0]       pph2_r;
  logic [49:0]       ppl2_r;

  logic              v3_r, op3_r, rsv3_r, zero3_r, sign3_r;
  mfsd_pkg::cls_t    cls3_r;
  logic [10:0]       exp3_r;
  logic [76:0]       prod3_r;

  logic              v4_r, op4_r, rsv4_r, zero4_r;
  mfsd_pkg::cls_t    cls4_r;
  logic [63:0]       dbl4_r;

  logic              out_valid_r, out_op_r;
  mfsd_pkg::cls_t    out_cls_r;
  logic [63:0]       out_bits_r;

  logic [23:0]    m1_nxt;
  logic [23:0]    mag1_nxt;
  logic [7:0]     idx1_nxt;
  logic [4:0]     pm1_nxt;
  logic [63:0]    rom1_nxt;
  logic           rsv1_nxt;
  logic [2:0]     off1_nxt;
  logic [23:0]    magn1_nxt;
  logic [10:0]    exp1_nxt;

  logic [63:0]    dbl4_nxt;
  logic [51:0]    frac4;
  logic [10:0]    e4;
  logic           g4, st4;

  logic [63:0]    out_bits_nxt;
  logic [34:0]    sf_hi;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_comb begin
    if (!op0_r) begin
      m1_nxt   = word0_r[23:0];
      idx1_nxt = {~word0_r[31], word0_r[30:24]};
      rsv1_nxt = (word0_r[23:0] >= mfsd_pkg::FLOAT_RES_FIRST) &&
                 (word0_r[23:0] <= mfsd_pkg::FLOAT_RES_LAST);
      off1_nxt = 3'(word0_r[23:0] - mfsd_pkg::FLOAT_RES_FIRST);
    end else begin
      m1_nxt   = {{12{word0_r[11]}}, word0_r[11:0]};
      idx1_nxt = mfsd_pkg::SFLOAT_IDX_BASE + {4'd0, ~word0_r[15], word0_r[14:12]};
      rsv1_nxt = (word0_r[11:0] >= mfsd_pkg::SFLOAT_RES_FIRST) &&
                 (word0_r[11:0] <= mfsd_pkg::SFLOAT_RES_LAST);
      off1_nxt = 3'(word0_r[11:0] - mfsd_pkg::SFLOAT_RES_FIRST);
    end
    mag1_nxt = m1_nxt[23] ? (24'd0 - m1_nxt) : m1_nxt;
    pm1_nxt  = 5'd0;
    for (int b = 0; b < 24; b++) begin
      if (mag1_nxt[b]) begin
        pm1_nxt = 5'(b);
      end
    end
    magn1_nxt = mag1_nxt << (5'd23 - pm1_nxt);
    rom1_nxt  = mfsd_pkg::POW10_ROM[idx1_nxt];
    exp1_nxt  = rom1_nxt[62:52] + {6'd0, pm1_nxt};
  end

  always_comb begin
    if (prod3_r[76]) begin
      frac4 = prod3_r[75:24];
      g4    = prod3_r[23];
      st4   = |prod3_r[22:0];
      e4    = exp3_r + 11'd1;
    end else begin
      frac4 = prod3_r[74:23];
      g4    = prod3_r[22];
      st4   = |prod3_r[21:0];
      e4    = exp3_r;
    end
    if (rsv3_r) begin
      unique case (cls3_r)
        mfsd_pkg::CLS_POS_INF: dbl4_nxt = mfsd_pkg::BITS_POS_INF;
        mfsd_pkg::CLS_NEG_INF: dbl4_nxt = mfsd_pkg::BITS_NEG_INF;
        default:               dbl4_nxt = mfsd_pkg::BITS_QNAN;
      endcase
    end else if (zero3_r) begin
      dbl4_nxt = '0;
    end else begin
      dbl4_nxt = {sign3_r, e4, frac4} + {63'd0, g4 && (st4 || frac4[0])};
    end
  end

  always_comb begin
    sf_hi = dbl4_r[63:29] + {34'd0, dbl4_r[28] && ((|dbl4_r[27:0]) || dbl4_r[29])};
    if (op4_r && !rsv4_r && !zero4_r) begin
      out_bits_nxt = {sf_hi, 29'd0};
    end else begin
      out_bits_nxt = dbl4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v0_r        <= in_valid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r   <= in_op;
      word0_r <= in_raw_word;

      op1_r   <= op0_r;
      rsv1_r  <= rsv1_nxt;
      cls1_r  <= rsv1_nxt ? mfsd_pkg::cls_t'(off1_nxt + 3'd1) : mfsd_pkg::CLS_FINITE;
      zero1_r <= (m1_nxt == '0);
      sign1_r <= m1_nxt[23];
      magn1_r <= magn1_nxt;
      exp1_r  <= exp1_nxt;
      sig1_r  <= {1'b1, rom1_nxt[51:0]};

      op2_r   <= op1_r;
      rsv2_r  <= rsv1_r;
      cls2_r  <= cls1_r;
      zero2_r <= zero1_r;
      sign2_r <= sign1_r;
      exp2_r  <= exp1_r;
      pph2_r  <= {27'd0, magn1_r} * {24'd0, sig1_r[52:26]};
      ppl2_r  <= {26'd0, magn1_r} * {24'd0, sig1_r[25:0]};

      op3_r   <= op2_r;
      rsv3_r  <= rsv2_r;
      cls3_r  <= cls2_r;
      zero3_r <= zero2_r;
      sign3_r <= sign2_r;
      exp3_r  <= exp2_r;
      prod3_r <= {pph2_r, 26'd0} + {27'd0, ppl2_r};

      op4_r   <= op3_r;
      rsv4_r  <= rsv3_r;
      cls4_r  <= cls3_r;
      zero4_r <= zero3_r;
      dbl4_r  <= dbl4_nxt;

      out_op_r   <= op4_r;
      out_cls_r  <= cls4_r;
      out_bits_r <= out_bits_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value_bits  = out_bits_r;
  assign out_value_class = out_cls_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_special_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_class != mfsd_pkg::CLS_FINITE |-> out_value_bits[62:52] == 11'h7FF)
    else $error("special class without all-ones exponent");

  a_finite_exp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_value_class == mfsd_pkg::CLS_FINITE |-> out_value_bits[62:52] != 11'h7FF)
    else $error("finite class with all-ones exponent");

  a_sfloat_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_op_r && out_value_class == mfsd_pkg::CLS_FINITE
      |-> out_value_bits[28:0] == 29'd0)
    else $error("SFLOAT result not single precision");

endmodule
